/* rtl/core/ccls_pkg.sv */
// shared types and constants for the rgb color classifier
`timescale 1ns / 1ps

package ccls_pkg;

  localparam int CHANNEL_WIDTH = 16;
  localparam int QUEUE_DEPTH   = 8;

  localparam int COUNT_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 16;
  localparam int SAT_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_SHIFT = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_RED_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_LIMIT  = 3'd4;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd1024;
  localparam logic [LIMIT_W-1:0] DARK_RESET  = 16'd0;
  localparam logic [SAT_W-1:0]   SAT_RESET   = 11'd1024;

  typedef enum logic [2:0] {
    CLS_BLACK   = 3'd0,
    CLS_WHITE   = 3'd1,
    CLS_RED     = 3'd2,
    CLS_GREEN   = 3'd3,
    CLS_BLUE    = 3'd4,
    CLS_CYAN    = 3'd5,
    CLS_MAGENTA = 3'd6,
    CLS_YELLOW  = 3'd7
  } color_class_t;

  // front pipeline status toward the queue and the credit check
  typedef struct packed {
    logic         push;
    color_class_t cls;
    logic [1:0]   inflight;
  } front_stat_t;

endpackage

/* rtl/core/ccls_front.sv */
// classification pipeline: gain scaling, dark test, saturation test and hue decision
`timescale 1ns / 1ps

module ccls_front #(
  parameter int CHANNEL_WIDTH = ccls_pkg::CHANNEL_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic [ccls_pkg::COUNT_W-1:0] in_clear_count,
  input  logic [ccls_pkg::COUNT_W-1:0] in_red_count,
  input  logic [ccls_pkg::COUNT_W-1:0] in_green_count,
  input  logic [ccls_pkg::COUNT_W-1:0] in_blue_count,
  input  logic [ccls_pkg::GAIN_W-1:0]  red_gain,
  input  logic [ccls_pkg::GAIN_W-1:0]  green_gain,
  input  logic [ccls_pkg::GAIN_W-1:0]  blue_gain,
  input  logic [ccls_pkg::LIMIT_W-1:0] dark_limit,
  input  logic [ccls_pkg::SAT_W-1:0]   sat_limit,
  output ccls_pkg::front_stat_t        stat
);

  localparam int CW   = CHANNEL_WIDTH;
  localparam int PW   = CW + ccls_pkg::GAIN_W;
  localparam int SW   = CW + 2;
  localparam int LW   = CW + 12;
  localparam int HW   = CW + 3;
  localparam int MW   = SW + ccls_pkg::SAT_W + 1;

  // stage 1: scaled channels
  logic [PW-1:0] r_prod, g_prod, b_prod;
  logic          dark_nxt;
  logic          v1_r, dark1_r;
  logic [CW-1:0] r1_r, g1_r, b1_r;

  always_comb begin
    r_prod   = in_red_count[CW-1:0] * red_gain;
    g_prod   = in_green_count[CW-1:0] * green_gain;
    b_prod   = in_blue_count[CW-1:0] * blue_gain;
    dark_nxt = {{(ccls_pkg::LIMIT_W-CW){1'b0}}, in_clear_count[CW-1:0]} < dark_limit;
  end

  // stage 2: min, sum and hue
  logic [CW-1:0]          lo;
  logic [SW-1:0]          sum_nxt, lo3;
  logic [LW-1:0]          lo_sh_nxt;
  logic signed [HW-1:0]   hx, hy, hd;
  logic [HW-1:0]          mx, my;
  ccls_pkg::color_class_t hue_nxt;
  logic                   v2_r, dark2_r;
  logic [SW-1:0]          sum2_r;
  logic [LW-1:0]          lo_sh2_r;
  ccls_pkg::color_class_t hue2_r;

  always_comb begin
    lo = r1_r;
    if (g1_r < lo) lo = g1_r;
    if (b1_r < lo) lo = b1_r;
    sum_nxt   = {2'b00, r1_r} + {2'b00, g1_r} + {2'b00, b1_r};
    lo3       = {2'b00, lo} + {1'b0, lo, 1'b0};
    lo_sh_nxt = {lo3, 10'b0};
    hx = $signed({2'b00, r1_r, 1'b0}) - $signed({3'b000, g1_r}) - $signed({3'b000, b1_r});
    hd = $signed({3'b000, g1_r}) - $signed({3'b000, b1_r});
    hy = hd + (hd <<< 1);
    mx = hx[HW-1] ? HW'(-hx) : HW'(hx);
    my = hy[HW-1] ? HW'(-hy) : HW'(hy);
    if (mx > my) begin
      hue_nxt = hx[HW-1] ? ccls_pkg::CLS_CYAN : ccls_pkg::CLS_RED;
    end else if (hx[HW-1]) begin
      hue_nxt = hy[HW-1] ? ccls_pkg::CLS_BLUE : ccls_pkg::CLS_GREEN;
    end else begin
      hue_nxt = hy[HW-1] ? ccls_pkg::CLS_MAGENTA : ccls_pkg::CLS_YELLOW;
    end
  end

  // stage 3: (limit + 1) * sum against 3072 * min
  logic [ccls_pkg::SAT_W:0] lim_p1;
  logic [MW-1:0]            prod_nxt;
  logic                     v3_r, dark3_r;
  logic [MW-1:0]            prod3_r;
  logic [LW-1:0]            lo_sh3_r;
  ccls_pkg::color_class_t   hue3_r;
  logic                     white;

  always_comb begin
    lim_p1   = {1'b0, sat_limit} + 1'b1;
    prod_nxt = lim_p1 * sum2_r;
    white    = {{(MW-LW){1'b0}}, lo_sh3_r} >= prod3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    r1_r     <= r_prod[CW+ccls_pkg::GAIN_SHIFT-1:ccls_pkg::GAIN_SHIFT];
    g1_r     <= g_prod[CW+ccls_pkg::GAIN_SHIFT-1:ccls_pkg::GAIN_SHIFT];
    b1_r     <= b_prod[CW+ccls_pkg::GAIN_SHIFT-1:ccls_pkg::GAIN_SHIFT];
    dark1_r  <= dark_nxt;
    sum2_r   <= sum_nxt;
    lo_sh2_r <= lo_sh_nxt;
    hue2_r   <= hue_nxt;
    dark2_r  <= dark1_r;
    prod3_r  <= prod_nxt;
    lo_sh3_r <= lo_sh2_r;
    hue3_r   <= hue2_r;
    dark3_r  <= dark2_r;
  end

  always_comb begin
    stat.push     = v3_r;
    stat.inflight = {1'b0, v1_r} + {1'b0, v2_r} + {1'b0, v3_r};
    if (dark3_r) begin
      stat.cls = ccls_pkg::CLS_BLACK;
    end else if (white) begin
      stat.cls = ccls_pkg::CLS_WHITE;
    end else begin
      stat.cls = hue3_r;
    end
  end

endmodule

/* rtl/core/ccls_queue.sv */
// result queue that decouples the classifier from the output channel
`timescale 1ns / 1ps

module ccls_queue #(
  parameter int QUEUE_DEPTH = ccls_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ccls_pkg::front_stat_t          stat,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_color_class
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

  ccls_pkg::color_class_t mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          push, pop;

  always_comb begin
    push       = stat.push;
    pop        = out_valid && !out_stall;
    wr_ptr_nxt = push ? ((wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? ((rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + NW'(push) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= stat.cls;
    end
  end

  assign level           = count_r;
  assign out_valid       = count_r != '0;
  assign out_color_class = mem_r[rd_ptr_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && (count_r == NW'(QUEUE_DEPTH)) |-> pop)
    else $error("push into full queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointer gap");

endmodule

/* rtl/core/rgb_color_classifier_top.sv */
// top level of the rgb color classifier: registers, credit check, front and queue
// path: an accepted input beat passes three pipeline registers, then the result queue,
//   on its way to the output
// throughput: one beat per cycle; in_stall rises when queued plus in-flight
//   results reach the queue depth
// reset: synchronous active-low rst_n empties pipeline and queue, gains to 1024,
//   dark limit to 0, saturation limit to 1024
`timescale 1ns / 1ps

module rgb_color_classifier_top #(
  parameter int CHANNEL_WIDTH = ccls_pkg::CHANNEL_WIDTH,
  parameter int QUEUE_DEPTH   = ccls_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ccls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccls_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ccls_pkg::COUNT_W-1:0]    in_clear_count,
  input  logic [ccls_pkg::COUNT_W-1:0]    in_red_count,
  input  logic [ccls_pkg::COUNT_W-1:0]    in_green_count,
  input  logic [ccls_pkg::COUNT_W-1:0]    in_blue_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_color_class
);

  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [ccls_pkg::GAIN_W-1:0]  red_gain_r, green_gain_r, blue_gain_r;
  logic [ccls_pkg::LIMIT_W-1:0] dark_limit_r;
  logic [ccls_pkg::SAT_W-1:0]   sat_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_gain_r   <= ccls_pkg::GAIN_RESET;
      green_gain_r <= ccls_pkg::GAIN_RESET;
      blue_gain_r  <= ccls_pkg::GAIN_RESET;
      dark_limit_r <= ccls_pkg::DARK_RESET;
      sat_limit_r  <= ccls_pkg::SAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ccls_pkg::CFG_RED_GAIN:   red_gain_r   <= cfg_wdata;
        ccls_pkg::CFG_GREEN_GAIN: green_gain_r <= cfg_wdata;
        ccls_pkg::CFG_BLUE_GAIN:  blue_gain_r  <= cfg_wdata;
        ccls_pkg::CFG_DARK_LIMIT: dark_limit_r <= cfg_wdata;
        ccls_pkg::CFG_SAT_LIMIT:  sat_limit_r  <= cfg_wdata[ccls_pkg::SAT_W-1:0];
        default: ;
      endcase
    end
  end

  ccls_pkg::front_stat_t stat;
  logic [NW-1:0]         level;
  logic [NW:0]           credit_used;
  logic                  in_fire;

  assign credit_used = {1'b0, level} + (NW+1)'(stat.inflight);
  assign in_stall    = credit_used >= (NW+1)'(QUEUE_DEPTH);
  assign in_fire     = in_valid && !in_stall;

  ccls_front #(
    .CHANNEL_WIDTH (CHANNEL_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_clear_count (in_clear_count),
    .in_red_count   (in_red_count),
    .in_green_count (in_green_count),
    .in_blue_count  (in_blue_count),
    .red_gain       (red_gain_r),
    .green_gain     (green_gain_r),
    .blue_gain      (blue_gain_r),
    .dark_limit     (dark_limit_r),
    .sat_limit      (sat_limit_r),
    .stat           (stat)
  );

  ccls_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk             (clk),
    .rst_n           (rst_n),
    .stat            (stat),
    .level           (level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_color_class (out_color_class)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_used <= (NW+1)'(QUEUE_DEPTH))
    else $error("queued plus in-flight results exceed queue depth");

  a_fire_reaches_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##3 stat.push)
    else $error("accepted beat did not reach the queue");

endmodule
